// File: hdl/ipv4psc_pkg.sv
// Package for the IPv4 prefix string checker.
// Holds the transaction structs, the form and error codes, and character constants.
// No dependencies.
package ipv4psc_pkg;

    // String forms
    localparam logic [1:0] FORM_PLAIN = 2'd0;
    localparam logic [1:0] FORM_SLASH = 2'd1;
    localparam logic [1:0] FORM_MASK  = 2'd2;
    localparam logic [1:0] FORM_ALIAS = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_FORM   = 3'd1;
    localparam logic [2:0] ERR_ADDR   = 3'd2;
    localparam logic [2:0] ERR_NONNUM = 3'd3;
    localparam logic [2:0] ERR_LEN    = 3'd4;
    localparam logic [2:0] ERR_HOST   = 3'd5;
    localparam logic [2:0] ERR_MASK   = 3'd6;

    // Characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Limits
    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [9:0]  LENGTH_MAX  = 10'd32;
    localparam logic [9:0]  LENGTH_TEN  = 10'd10;

    typedef struct packed {
        logic [7:0] character;
        logic [1:0] form;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [2:0]  error_code;
        logic [31:0] address;
        logic [5:0]  prefix_length;
    } res_item_t;

endpackage

// File: hdl/ipv4_prefix_string_checker_top.sv
// Top level of the IPv4 prefix string checker: character input register,
// per-character parse step, and result register. Uses ipv4psc_pkg.
// A result is registered in the result register once its last character, held in the input register, is parsed.
// Throughput: one character per cycle; a last character waits only while a result stalls.
// Reset: asynchronous, active low; clears all parse state and both valid flags,
// leaving the checker at the start of a new string.
module ipv4_prefix_string_checker_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  ipv4psc_pkg::char_item_t char_item,
    output logic                    res_valid,
    input  logic                    res_stall,
    output ipv4psc_pkg::res_item_t  res_item
);
    import ipv4psc_pkg::*;

    // Input register
    logic       in_valid_reg;
    char_item_t in_reg;

    // Result register
    logic      out_valid_reg;
    logic      out_valid_next;
    res_item_t out_reg;
    res_item_t out_next;

    // Parse state
    logic [1:0]  form_reg,      form_next;
    logic        start_reg,     start_next;
    logic        in_len_reg,    in_len_next;
    logic [1:0]  pos_reg,       pos_next;
    logic [7:0]  oct_reg,       oct_next;
    logic        has_digit_reg, has_digit_next;
    logic [31:0] addr_reg,      addr_next;
    logic [9:0]  len_reg,       len_next;
    logic [1:0]  len_cnt_reg,   len_cnt_next;
    logic [2:0]  err_reg,       err_next;

    // Step control
    logic        out_free;
    logic        proc_go;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] oct_sum;
    logic [9:0]  len_sum;
    logic [2:0]  err_final;
    logic [31:0] net_mask;
    logic [31:0] inv_addr;
    logic [1:0]  shift_pos;

    // Handshake
    assign out_free   = !out_valid_reg || !res_stall;
    assign proc_go    = in_valid_reg && (!in_reg.last || out_free);
    assign char_stall = in_valid_reg && !proc_go;
    assign res_valid  = out_valid_reg;
    assign res_item   = out_reg;

    // Decode the current character
    assign is_digit = (in_reg.character >= CHAR_ZERO) && (in_reg.character <= CHAR_NINE);
    assign digit    = in_reg.character[3:0];
    assign oct_sum  = {1'b0, oct_reg, 3'b000} + {3'b000, oct_reg, 1'b0} + {8'd0, digit};
    assign len_sum  = {len_reg[6:0], 3'b000} + {len_reg[8:0], 1'b0} + {6'd0, digit};

    // Parse one character and, on the last one, finish the string
    always_comb
    begin
        form_next      = start_reg ?
                         ((in_reg.form == FORM_ALIAS) ? FORM_MASK : in_reg.form) : form_reg;
        start_next     = 1'b0;
        in_len_next    = in_len_reg;
        pos_next       = pos_reg;
        oct_next       = oct_reg;
        has_digit_next = has_digit_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        len_cnt_next   = len_cnt_reg;
        err_next       = err_reg;
        err_final      = ERR_NONE;
        net_mask       = '0;
        inv_addr       = '0;
        shift_pos      = pos_reg;
        out_next       = out_reg;

        if (in_len_reg)
        begin
            // Length part: only the first three characters count
            if (len_cnt_reg != 2'd3)
            begin
                if (is_digit)
                begin
                    len_next = len_sum;
                end
                else if (err_next == ERR_NONE)
                begin
                    err_next = ERR_NONNUM;
                end
                len_cnt_next = len_cnt_reg + 2'd1;
            end
        end
        else if (is_digit)
        begin
            // Accumulate an octet digit, drop it on overflow
            if (oct_sum > OCTET_MAX)
            begin
                if (err_next == ERR_NONE)
                begin
                    err_next = ERR_ADDR;
                end
            end
            else
            begin
                oct_next = oct_sum[7:0];
            end
            has_digit_next = 1'b1;
        end
        else if (in_reg.character == CHAR_DOT)
        begin
            if (pos_reg == 2'd3)
            begin
                if (err_next == ERR_NONE)
                begin
                    err_next = ERR_ADDR;
                end
            end
            else
            begin
                if (!has_digit_reg)
                begin
                    if (err_next == ERR_NONE)
                    begin
                        err_next = ERR_ADDR;
                    end
                end
                else
                begin
                    addr_next = addr_next | ({24'd0, oct_reg} << {~pos_reg, 3'b000});
                end
                oct_next       = '0;
                has_digit_next = 1'b0;
                pos_next       = pos_reg + 2'd1;
            end
        end
        else if (in_reg.character == CHAR_SLASH && form_next != FORM_MASK)
        begin
            if (!has_digit_reg)
            begin
                if (err_next == ERR_NONE)
                begin
                    err_next = ERR_ADDR;
                end
            end
            else
            begin
                addr_next = addr_next | ({24'd0, oct_reg} << {~pos_reg, 3'b000});
            end
            oct_next       = '0;
            has_digit_next = 1'b0;
            in_len_next    = 1'b1;
        end
        else if (err_next == ERR_NONE)
        begin
            err_next = ERR_ADDR;
        end

        if (in_reg.last)
        begin
            // Close the final octet
            if (!in_len_next)
            begin
                shift_pos = pos_next;
                if (!has_digit_next)
                begin
                    if (err_next == ERR_NONE)
                    begin
                        err_next = ERR_ADDR;
                    end
                end
                else
                begin
                    addr_next = addr_next | ({24'd0, oct_next} << {~shift_pos, 3'b000});
                end
            end

            err_final = err_next;

            // Length and host-bit checks
            if (err_final == ERR_NONE && form_next == FORM_SLASH && in_len_next)
            begin
                if (len_cnt_next == 2'd0 || len_cnt_next == 2'd3 || len_next > LENGTH_MAX ||
                    (len_next < LENGTH_TEN && len_cnt_next == 2'd2))
                begin
                    err_final = ERR_LEN;
                end
                else
                begin
                    net_mask = 32'hFFFF_FFFF << (6'd32 - len_next[5:0]);
                    if ((addr_next & ~net_mask) != 32'd0)
                    begin
                        err_final = ERR_HOST;
                    end
                end
            end

            // Netmask contiguity check
            if (err_final == ERR_NONE && form_next == FORM_MASK)
            begin
                inv_addr = ~addr_next;
                if ((inv_addr & (inv_addr + 32'd1)) != 32'd0)
                begin
                    err_final = ERR_MASK;
                end
            end

            // Slash presence overrides every other error
            if ((form_next == FORM_PLAIN && in_len_next) ||
                (form_next == FORM_SLASH && !in_len_next))
            begin
                err_final = ERR_FORM;
            end

            out_next.valid_res     = (err_final == ERR_NONE);
            out_next.error_code    = err_final;
            out_next.address       = (err_final == ERR_NONE) ? addr_next : 32'd0;
            out_next.prefix_length = (err_final == ERR_NONE && form_next == FORM_SLASH) ?
                                     len_next[5:0] : 6'd0;

            // Return to the start of a new string
            form_next      = FORM_PLAIN;
            start_next     = 1'b1;
            in_len_next    = 1'b0;
            pos_next       = '0;
            oct_next       = '0;
            has_digit_next = 1'b0;
            addr_next      = '0;
            len_next       = '0;
            len_cnt_next   = '0;
            err_next       = ERR_NONE;
        end
    end

    assign out_valid_next = (proc_go && in_reg.last) ? 1'b1 : (out_valid_reg && res_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            form_reg      <= FORM_PLAIN;
            start_reg     <= 1'b1;
            in_len_reg    <= 1'b0;
            pos_reg       <= '0;
            oct_reg       <= '0;
            has_digit_reg <= 1'b0;
            addr_reg      <= '0;
            len_reg       <= '0;
            len_cnt_reg   <= '0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            // Take a new transaction whenever the input register is not held
            if (!char_stall)
            begin
                in_valid_reg <= char_valid;
            end
            // Advance parse state
            if (proc_go)
            begin
                form_reg      <= form_next;
                start_reg     <= start_next;
                in_len_reg    <= in_len_next;
                pos_reg       <= pos_next;
                oct_reg       <= oct_next;
                has_digit_reg <= has_digit_next;
                addr_reg      <= addr_next;
                len_reg       <= len_next;
                len_cnt_reg   <= len_cnt_next;
                err_reg       <= err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            in_reg <= char_item;
        end
        if (proc_go && in_reg.last)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: dv/ipv4_prefix_string_checker_top_test.sv
// Self-checking testbench for ipv4_prefix_string_checker_top: directed strings, then random
// dotted IPv4 text in all forms, checked against an in-bench parser of the same rules.
// Depends on ipv4psc_pkg and the checker RTL only.
module ipv4_prefix_string_checker_top_test;
    import ipv4psc_pkg::*;

    localparam int RANDOM_CHARS = 1450;
    localparam int TAIL_CHARS   = 150;
    localparam int LONG_HOLD    = 200;

    typedef struct {
        string       text;
        logic [1:0]  form;
        bit          typed;
        logic [2:0]  err;
        logic [31:0] addr;
        logic [5:0]  plen;
    } text_case_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid;
    logic       char_stall;
    char_item_t char_item;
    logic       res_valid;
    logic       res_stall;
    res_item_t  res_item;

    res_item_t  pending_verdicts[$];
    text_case_t directed_cases[$];
    int         fault_count = 0;
    bit         quiet_tail = 1'b0;
    bit         long_hold_due = 1'b0;
    bit         long_hold_done = 1'b0;

    // Parser state of the checker as predicted by the bench
    logic [1:0]  cur_form;
    bit          at_first_char;
    bit          after_slash;
    logic [1:0]  octet_idx;
    logic [7:0]  octet_val;
    bit          octet_digits;
    logic [31:0] addr_so_far;
    logic [9:0]  len_val;
    logic [1:0]  len_chars;
    logic [2:0]  first_fault;

    ipv4_prefix_string_checker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_item (char_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_parse();
        cur_form      = FORM_PLAIN;
        at_first_char = 1'b1;
        after_slash   = 1'b0;
        octet_idx     = '0;
        octet_val     = '0;
        octet_digits  = 1'b0;
        addr_so_far   = '0;
        len_val       = '0;
        len_chars     = '0;
        first_fault   = ERR_NONE;
    endfunction

    function automatic void flag_error(logic [2:0] code);
        if (first_fault == ERR_NONE)
            first_fault = code;
    endfunction

    // Store the finished octet in its byte lane, or flag it as empty
    function automatic void end_octet();
        if (!octet_digits)
            flag_error(ERR_ADDR);
        else
            addr_so_far |= {24'd0, octet_val} << (24 - 8 * octet_idx);
        octet_val    = '0;
        octet_digits = 1'b0;
    endfunction

    // Advance the parser by one character; return 1 with the verdict on the last one
    function automatic bit parse_char(input char_item_t item, output res_item_t verdict);
        int unsigned sum;
        logic [2:0]  code;
        logic [31:0] net_mask;
        logic [31:0] inverse;
        bit          is_digit;
        bit          ok;
        verdict  = '0;
        is_digit = item.character >= CHAR_ZERO && item.character <= CHAR_NINE;
        if (at_first_char)
        begin
            cur_form      = (item.form == FORM_ALIAS) ? FORM_MASK : item.form;
            at_first_char = 1'b0;
        end

        if (after_slash)
        begin
            // only the first three length characters count
            if (len_chars != 2'd3)
            begin
                if (is_digit)
                    len_val = 10'(len_val * 10 + (item.character - CHAR_ZERO));
                else
                    flag_error(ERR_NONNUM);
                len_chars++;
            end
        end
        else if (is_digit)
        begin
            sum = octet_val * 10 + (item.character - CHAR_ZERO);
            if (sum > 255)
                flag_error(ERR_ADDR);
            else
                octet_val = sum[7:0];
            octet_digits = 1'b1;
        end
        else if (item.character == CHAR_DOT)
        begin
            if (octet_idx == 2'd3)
                flag_error(ERR_ADDR);
            else
            begin
                end_octet();
                octet_idx++;
            end
        end
        else if (item.character == CHAR_SLASH && cur_form != FORM_MASK)
        begin
            end_octet();
            after_slash = 1'b1;
        end
        else
            flag_error(ERR_ADDR);

        if (!item.last)
            return 1'b0;

        if (!after_slash)
            end_octet();
        code = first_fault;
        if (code == ERR_NONE && cur_form == FORM_SLASH && after_slash)
        begin
            if (len_chars == 2'd0 || len_chars == 2'd3 || len_val > LENGTH_MAX ||
                (len_val < LENGTH_TEN && len_chars == 2'd2))
                code = ERR_LEN;
            else
            begin
                net_mask = (len_val == 0) ? '0 : ~32'd0 << (32 - len_val);
                if ((addr_so_far & ~net_mask) != 0)
                    code = ERR_HOST;
            end
        end
        if (code == ERR_NONE && cur_form == FORM_MASK)
        begin
            inverse = ~addr_so_far;
            if ((inverse & (inverse + 32'd1)) != 0)
                code = ERR_MASK;
        end
        // a slash in the wrong form overrides every other error
        if ((cur_form == FORM_PLAIN && after_slash) || (cur_form == FORM_SLASH && !after_slash))
            code = ERR_FORM;

        ok = (code == ERR_NONE);
        verdict.valid_res     = ok;
        verdict.error_code    = code;
        verdict.address       = ok ? addr_so_far : '0;
        verdict.prefix_length = (ok && cur_form == FORM_SLASH) ? len_val[5:0] : '0;
        restart_parse();
        return 1'b1;
    endfunction

    function automatic void add_case(string text, logic [1:0] form, bit typed,
                                     logic [2:0] err, logic [31:0] addr, logic [5:0] plen);
        text_case_t row;
        row.text  = text;
        row.form  = form;
        row.typed = typed;
        row.err   = err;
        row.addr  = addr;
        row.plen  = plen;
        directed_cases.push_back(row);
    endfunction

    function automatic string octet_text(int unsigned v);
        case ($urandom_range(0, 19))
            0: return $sformatf("0%0d", v);
            1: return $sformatf("00%0d", v);
            2: return $sformatf("%0d", v + 256);
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    // Build one random string: mostly well formed in its form, some of it damaged
    task automatic compose_random(output byte unsigned txt[$], output logic [1:0] str_form);
        string       s;
        string       lt;
        int          plen;
        int          octets;
        int          spot;
        logic [31:0] a;
        logic [31:0] m;
        txt      = {};
        str_form = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 6))
                txt.push_back(8'($urandom_range(1, 255)));
            return;
        end

        plen = $urandom_range(0, 32);
        m    = (plen == 0) ? '0 : ~32'd0 << (32 - plen);
        if (str_form >= FORM_MASK)
        begin
            a = m;
            if ($urandom_range(0, 5) == 0)
                a[$urandom_range(0, 31)] ^= 1'b1;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(0, 3))
                    0: a[31 - 8 * i -: 8] = 8'h00;
                    1: a[31 - 8 * i -: 8] = 8'hFF;
                    default: a[31 - 8 * i -: 8] = 8'($urandom());
                endcase
            end
            if (str_form == FORM_SLASH && $urandom_range(0, 3) != 0)
                a &= m;
        end

        octets = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 4;
        s = "";
        for (int i = 0; i < octets; i++)
        begin
            if (i != 0)
                s = {s, "."};
            s = {s, octet_text(32'(a[31 - 8 * i -: 8]))};
        end

        if ((str_form == FORM_SLASH && $urandom_range(0, 9) != 0) ||
            (str_form == FORM_PLAIN && $urandom_range(0, 9) == 0))
        begin
            case ($urandom_range(0, 11))
                0: lt = "";
                1: lt = $sformatf("0%0d", plen % 10);
                2: lt = $sformatf("%0d", $urandom_range(33, 99));
                3: lt = $sformatf("%03d", plen);
                4: lt = $sformatf("%0d%c", plen, 8'($urandom_range(1, 255)));
                5: lt = $sformatf("%c%0d", 8'($urandom_range(1, 255)), plen);
                default: lt = $sformatf("%0d", plen);
            endcase
            s = {s, "/", lt};
        end
        else if (str_form >= FORM_MASK && $urandom_range(0, 14) == 0)
            s = {s, "/8"};

        for (int j = 0; j < s.len(); j++)
            txt.push_back(s[j]);

        // damage a few strings: replace, insert a separator, or drop a character
        if ($urandom_range(0, 7) == 0)
        begin
            spot = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0: txt[spot] = 8'($urandom_range(1, 255));
                1: txt.insert(spot, ($urandom_range(0, 1) != 0) ? CHAR_DOT : CHAR_SLASH);
                default:
                    if (txt.size() > 1)
                        txt.delete(spot);
            endcase
        end
    endtask

    // Offer one string a character per transaction; predict on each acceptance
    task automatic send_text(input byte unsigned txt[$], input logic [1:0] str_form,
                             input bit typed, input res_item_t want);
        char_item_t item;
        res_item_t  guess;
        bit         calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (txt[i])
        begin
            item.character = txt[i];
            item.form      = (i == 0) ? str_form : 2'($urandom_range(0, 3));
            item.last      = (i == txt.size() - 1);
            if (!quiet_tail && !calm && $urandom_range(0, 7) == 0)
            begin
                char_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            char_valid <= 1'b1;
            char_item  <= item;
            do
                @(posedge clk);
            while (char_stall);
            if (parse_char(item, guess))
                pending_verdicts.push_back(typed ? want : guess);
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        byte unsigned txt[$];
        byte unsigned b;
        logic [1:0]   str_form;
        res_item_t    want;
        int           sent;
        char_valid = 1'b0;
        char_item  = '0;
        restart_parse();

        // '#' stands for a zero byte (8'h00) in the directed text
        add_case("255.255.255.255", FORM_PLAIN, 1, ERR_NONE, 32'hFFFF_FFFF, 6'd0);
        add_case("0", FORM_PLAIN, 1, ERR_NONE, 32'h0000_0000, 6'd0);
        add_case("001.02.3", FORM_PLAIN, 1, ERR_NONE, 32'h0102_0300, 6'd0);
        add_case("256.1.1.1", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case("1..2", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case(".1", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case("1.", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case("1.2.3.4.5", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case("1#2", FORM_PLAIN, 1, ERR_ADDR, '0, '0);
        add_case("10.0.0.0/8", FORM_PLAIN, 1, ERR_FORM, '0, '0);
        add_case("10.0.0.0", FORM_SLASH, 1, ERR_FORM, '0, '0);
        add_case("300/8", FORM_PLAIN, 1, ERR_FORM, '0, '0);
        add_case("10.0.0.0/8", FORM_SLASH, 1, ERR_NONE, 32'h0A00_0000, 6'd8);
        add_case("0.0.0.0/0", FORM_SLASH, 1, ERR_NONE, 32'h0000_0000, 6'd0);
        add_case("255.255.255.255/32", FORM_SLASH, 1, ERR_NONE, 32'hFFFF_FFFF, 6'd32);
        add_case("1.2.3.4/33", FORM_SLASH, 1, ERR_LEN, '0, '0);
        add_case("1.2.3.4/08", FORM_SLASH, 1, ERR_LEN, '0, '0);
        add_case("1.2.3.4/", FORM_SLASH, 1, ERR_LEN, '0, '0);
        add_case("1.0.0.0/100", FORM_SLASH, 1, ERR_LEN, '0, '0);
        add_case("1.2.3.4/2x9zz", FORM_SLASH, 1, ERR_NONNUM, '0, '0);
        add_case("10.1/8", FORM_SLASH, 1, ERR_HOST, '0, '0);
        add_case("192.168.1.0/24", FORM_SLASH, 0, ERR_NONE, '0, '0);
        add_case("255.255.240", FORM_MASK, 1, ERR_NONE, 32'hFFFF_F000, 6'd0);
        add_case("255.0.255", FORM_MASK, 1, ERR_MASK, '0, '0);
        add_case("255.255.0.0", FORM_ALIAS, 1, ERR_NONE, 32'hFFFF_0000, 6'd0);
        add_case("255/8", FORM_MASK, 1, ERR_ADDR, '0, '0);
        add_case("0.0.0.0", FORM_MASK, 0, ERR_NONE, '0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the directed strings
        foreach (directed_cases[k])
        begin
            txt = {};
            for (int j = 0; j < directed_cases[k].text.len(); j++)
            begin
                b = directed_cases[k].text[j];
                txt.push_back((b == "#") ? 8'h00 : b);
            end
            want.valid_res     = (directed_cases[k].err == ERR_NONE);
            want.error_code    = directed_cases[k].err;
            want.address       = directed_cases[k].addr;
            want.prefix_length = directed_cases[k].plen;
            send_text(txt, directed_cases[k].form, directed_cases[k].typed, want);
        end

        // random strings; the receiver backs up once at the start
        long_hold_due = 1'b1;
        sent = 0;
        while (sent < RANDOM_CHARS)
        begin
            compose_random(txt, str_form);
            quiet_tail = (sent > RANDOM_CHARS - TAIL_CHARS);
            send_text(txt, str_form, 1'b0, '0);
            sent += txt.size();
        end
        char_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Drive the result stall: short bursts, calm stretches, and one long hold
    initial
    begin : result_sink
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_due && !long_hold_done)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
                if ($urandom_range(0, 15) == 0)
                    repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    // Compare each accepted result transaction with the oldest pending verdict
    always @(posedge clk)
    begin : verdict_check
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no string pending: error_code %0d, address %h",
                       res_item.error_code, res_item.address);
                fault_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_item.valid_res !== want.valid_res)
                begin
                    $error("valid_res: expected %0d, got %0d", want.valid_res,
                           res_item.valid_res);
                    fault_count++;
                end
                if (res_item.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           res_item.error_code);
                    fault_count++;
                end
                if (res_item.address !== want.address)
                begin
                    $error("address: expected %h, got %h", want.address, res_item.address);
                    fault_count++;
                end
                if (res_item.prefix_length !== want.prefix_length)
                begin
                    $error("prefix_length: expected %0d, got %0d", want.prefix_length,
                           res_item.prefix_length);
                    fault_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hdl/ipv4psc_pkg.sv
hdl/ipv4_prefix_string_checker_top.sv
dv/ipv4_prefix_string_checker_top_test.sv
